// ----- rtl/core/dfmc_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// dfmc_pkg
// Shared types, codes and thresholds of the drag flap mode controller.
// ============================================================================
package dfmc_pkg;

    localparam int TIMER_BITS_DEF = 20;
    localparam int CFG_W          = 20;
    localparam int MODE_W         = 3;
    localparam int CFG_ADDR_W     = 2;
    localparam int IN_TDATA_W     = 56;
    localparam int OUT_TDATA_W    = 8;

    // Mode codes
    localparam logic [MODE_W-1:0] MODE_CLOSED = 3'd0;
    localparam logic [MODE_W-1:0] MODE_OPEN   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MANUAL = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ASSIST = 3'd3;
    localparam logic [MODE_W-1:0] MODE_AUTO   = 3'd4;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_MODE       = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_AUTO_HOLD  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_OPEN_WAIT  = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_CLOSE_WAIT = 2'd3;

    // Register reset values
    localparam logic [MODE_W-1:0] RST_MODE       = MODE_MANUAL;
    localparam logic [CFG_W-1:0]  RST_AUTO_HOLD  = 20'd250000;
    localparam logic [CFG_W-1:0]  RST_OPEN_WAIT  = 20'd45000;
    localparam logic [CFG_W-1:0]  RST_CLOSE_WAIT = 20'd10000;

    // Fixed-point thresholds (brake and throttle fractions in thousandths, steering in degrees)
    localparam logic [9:0]  BRAKE_FORCE_CLOSE = 10'd200;
    localparam logic [9:0]  BRAKE_AUTO_LIMIT  = 10'd50;
    localparam logic [9:0]  THROTTLE_AUTO_MIN = 10'd850;
    localparam logic [9:0]  THROTTLE_LIFT     = 10'd50;
    localparam logic signed [8:0] STEER_FORCE_CLOSE = 9'sd15;
    localparam logic signed [8:0] STEER_AUTO_LIMIT  = 9'sd10;
    // mph = floor(kph*62/100) > 25  <=>  kph*62 >= 26*100
    localparam logic [13:0] KPH_TO_MPH_NUM    = 14'd62;
    localparam logic [13:0] MPH_OPEN_SCALED   = 14'd2600;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CFG_W-1:0]  auto_hold;
        logic [CFG_W-1:0]  open_wait;
        logic [CFG_W-1:0]  close_wait;
    } t_cfg;

    typedef struct packed {
        logic              button;
        logic signed [8:0] steer;
        logic [9:0]        brake;
        logic [9:0]        throttle;
        logic [7:0]        speed;
        logic [15:0]       elapsed;
    } t_tick;

    typedef struct packed {
        logic flap;
        logic auto_flag;
        logic hold_run;
    } t_flags;

endpackage

// ----- rtl/core/dfmc_cfg_regs.sv -----
`timescale 1ns / 1ps
// ============================================================================
// dfmc_cfg_regs
// Write-only configuration register file.
// ============================================================================
module dfmc_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [dfmc_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [dfmc_pkg::CFG_W-1:0]     i_cfg_wdata,
    output dfmc_pkg::t_cfg                 o_cfg
);
    import dfmc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_MODE:       n_cfg.mode       = i_cfg_wdata[MODE_W-1:0];
                REG_AUTO_HOLD:  n_cfg.auto_hold  = i_cfg_wdata;
                REG_OPEN_WAIT:  n_cfg.open_wait  = i_cfg_wdata;
                REG_CLOSE_WAIT: n_cfg.close_wait = i_cfg_wdata;
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode       <= RST_MODE;
            r_cfg.auto_hold  <= RST_AUTO_HOLD;
            r_cfg.open_wait  <= RST_OPEN_WAIT;
            r_cfg.close_wait <= RST_CLOSE_WAIT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/core/dfmc_decide.sv -----
`timescale 1ns / 1ps
// ============================================================================
// dfmc_decide
// Next-state logic for one control tick: timer update and mode decisions.
// ============================================================================
module dfmc_decide #(
    parameter int TIMER_BITS = dfmc_pkg::TIMER_BITS_DEF
) (
    input  dfmc_pkg::t_cfg         i_cfg,
    input  dfmc_pkg::t_tick        i_tick,
    input  dfmc_pkg::t_flags       i_flags,
    input  logic [TIMER_BITS-1:0]  i_toggle,
    input  logic [TIMER_BITS-1:0]  i_hold,
    output dfmc_pkg::t_flags       o_flags,
    output logic [TIMER_BITS-1:0]  o_toggle,
    output logic [TIMER_BITS-1:0]  o_hold
);
    import dfmc_pkg::*;

    localparam int CW = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

    logic [TIMER_BITS:0]   toggle_sum;
    logic [TIMER_BITS:0]   hold_sum;
    logic [TIMER_BITS-1:0] toggle_acc;
    logic [TIMER_BITS-1:0] hold_acc;
    logic [CW-1:0]         toggle_cmp;
    logic [CW-1:0]         hold_cmp;
    logic [13:0]           kph_scaled;
    logic                  open_lock_done;
    logic                  close_lock_done;
    logic                  hold_done;
    logic                  force_close;
    logic                  open_ok;
    logic                  close_cmd;

    // Saturating accumulate of elapsed time
    assign toggle_sum = {1'b0, i_toggle} + (TIMER_BITS + 1)'(i_tick.elapsed);
    assign hold_sum   = {1'b0, i_hold} + (TIMER_BITS + 1)'(i_tick.elapsed);
    assign toggle_acc = toggle_sum[TIMER_BITS] ? '1 : toggle_sum[TIMER_BITS-1:0];
    assign hold_acc   = !i_flags.hold_run ? i_hold :
                        (hold_sum[TIMER_BITS] ? '1 : hold_sum[TIMER_BITS-1:0]);

    assign toggle_cmp      = CW'(toggle_acc);
    assign hold_cmp        = CW'(hold_acc);
    assign open_lock_done  = toggle_cmp >= CW'(i_cfg.open_wait);
    assign close_lock_done = toggle_cmp >= CW'(i_cfg.close_wait);
    assign hold_done       = hold_cmp >= CW'(i_cfg.auto_hold);

    assign kph_scaled  = 14'(i_tick.speed) * KPH_TO_MPH_NUM;
    assign force_close = (i_tick.brake > BRAKE_FORCE_CLOSE)
                      || (i_tick.steer > STEER_FORCE_CLOSE)
                      || (i_tick.steer < -STEER_FORCE_CLOSE);
    assign open_ok     = (kph_scaled >= MPH_OPEN_SCALED)
                      && (i_tick.throttle > THROTTLE_AUTO_MIN)
                      && (i_tick.steer > -STEER_AUTO_LIMIT)
                      && (i_tick.steer < STEER_AUTO_LIMIT)
                      && (i_tick.brake <= BRAKE_AUTO_LIMIT);
    assign close_cmd   = (i_tick.brake > BRAKE_AUTO_LIMIT)
                      || (i_tick.throttle < THROTTLE_LIFT);

    always_comb begin
        o_flags  = i_flags;
        o_toggle = toggle_acc;
        o_hold   = hold_acc;
        unique case (i_cfg.mode)
            MODE_CLOSED: o_flags.flap = 1'b0;
            MODE_OPEN:   o_flags.flap = 1'b1;
            MODE_MANUAL: o_flags.flap = i_tick.button;
            MODE_ASSIST: begin
                if (!i_flags.flap && i_tick.button && open_lock_done) begin
                    o_toggle     = '0;
                    o_flags.flap = 1'b1;
                end else if (i_flags.flap && i_tick.button && close_lock_done) begin
                    o_toggle     = '0;
                    o_flags.flap = 1'b0;
                end
                if (o_flags.flap && force_close) begin
                    o_flags.flap = 1'b0;
                end
            end
            MODE_AUTO: begin
                if (!i_flags.flap) begin
                    if (open_ok) begin
                        if (!i_flags.hold_run) begin
                            o_flags.hold_run = 1'b1;
                            o_hold           = '0;
                        end else if (hold_done) begin
                            o_flags.auto_flag = 1'b1;
                            o_flags.flap      = 1'b1;
                            o_flags.hold_run  = 1'b0;
                            o_hold            = '0;
                        end
                    end else begin
                        o_flags.hold_run = 1'b0;
                        o_hold           = '0;
                    end
                end else if (close_cmd) begin
                    o_flags.auto_flag = 1'b0;
                    o_flags.flap      = 1'b0;
                    o_flags.hold_run  = 1'b0;
                    o_hold            = '0;
                end
            end
            default: begin
                // unused mode codes: hold everything but the timer advance
                o_flags = i_flags;
            end
        endcase
    end

endmodule

// ----- rtl/core/drag_flap_mode_controller.sv -----
`timescale 1ns / 1ps
// ============================================================================
// drag_flap_mode_controller
// Drag flap mode controller: one control tick in, one flap command out.
// ============================================================================
//
//  Channel   Direction  Handshake          Contents
//  s_axis    in         tvalid / tready    one control tick (sensor sample)
//  m_axis    out        tvalid / tready    flap state, drive lines, auto flag
//  cfg       in         write enable only  mode, auto hold, assist lockouts
//
//  Flow: a tick is captured in the input register, decided by one pass of
//  next-state logic and written to the result register once the result
//  slot is free; a new tick is taken every cycle unless the output stalls.
//  Reset: synchronous, active low; flap closed, toggle timer saturated.
//  Stalls: a held result stalls the input register only while it is full.
// ============================================================================
module drag_flap_mode_controller #(
    parameter int TIMER_BITS = dfmc_pkg::TIMER_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // tick input
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // [0] button, [9:1] steering_deg, [19:10] brake_frac,
    // [29:20] throttle_frac, [37:30] speed_kph, [53:38] elapsed_us
    input  logic [dfmc_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // result output
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [0] flap_open, [1] open_drive, [2] close_drive, [3] auto_active
    output logic [dfmc_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [dfmc_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [dfmc_pkg::CFG_W-1:0]       i_cfg_wdata
);
    import dfmc_pkg::*;

    t_cfg                  cfg;
    t_tick                 tick_in;
    t_tick                 r_tick;
    logic                  r_in_valid;
    logic                  r_out_valid;
    logic                  out_free;
    logic                  in_adv;
    t_flags                r_flags;
    t_flags                n_flags;
    logic [TIMER_BITS-1:0] r_toggle;
    logic [TIMER_BITS-1:0] n_toggle;
    logic [TIMER_BITS-1:0] r_hold;
    logic [TIMER_BITS-1:0] n_hold;
    logic                  r_res_flap;
    logic                  r_res_auto;

    dfmc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // Unpack the tick fields from tdata
    assign tick_in.button   = i_s_axis_tdata[0];
    assign tick_in.steer    = i_s_axis_tdata[9:1];
    assign tick_in.brake    = i_s_axis_tdata[19:10];
    assign tick_in.throttle = i_s_axis_tdata[29:20];
    assign tick_in.speed    = i_s_axis_tdata[37:30];
    assign tick_in.elapsed  = i_s_axis_tdata[53:38];

    // Two-stage pipeline handshake: advance whenever the result slot frees up
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign in_adv          = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    // Capture tick payload on every input transaction
    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_tick <= tick_in;
        end
    end

    dfmc_decide #(
        .TIMER_BITS (TIMER_BITS)
    ) u_decide (
        .i_cfg    (cfg),
        .i_tick   (r_tick),
        .i_flags  (r_flags),
        .i_toggle (r_toggle),
        .i_hold   (r_hold),
        .o_flags  (n_flags),
        .o_toggle (n_toggle),
        .o_hold   (n_hold)
    );

    // Controller state: advance once per tick that moves into the result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags  <= '0;
            r_toggle <= '1;
            r_hold   <= '0;
        end else if (in_adv) begin
            r_flags  <= n_flags;
            r_toggle <= n_toggle;
            r_hold   <= n_hold;
        end
    end

    // Result register: hold until the output transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv) begin
            r_res_flap <= n_flags.flap;
            r_res_auto <= n_flags.auto_flag;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000, r_res_auto, !r_res_flap, r_res_flap, r_res_flap};

`ifndef NO_ASSERTIONS
    // Input stage holds its tick while the result stage is blocked
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_free) |=> (r_in_valid && $stable(r_tick)))
        else $error("input stage lost a tick under stall");

    // State moves only when a tick advances
    a_state_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_adv |=> ($stable(r_flags) && $stable(r_toggle) && $stable(r_hold)))
        else $error("controller state changed without a tick");

    // Toggle timer only drops by being cleared in assistive mode
    a_toggle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_adv && (n_toggle < r_toggle)) |-> ((cfg.mode == MODE_ASSIST) && (n_toggle == '0)))
        else $error("toggle timer dropped outside an assistive toggle");

    // Every advanced tick produces a pending result
    a_result_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_adv |=> r_out_valid)
        else $error("advanced tick produced no result");
`endif

endmodule
